[rtl/sparse_argmax_argmin_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the sparse argmax / argmin unit
// Shared helpers for concurrent checks with an asynchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef SPARSE_ARGMAX_ARGMIN_UNIT_MACROS_SVH
`define SPARSE_ARGMAX_ARGMIN_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sam_pkg.sv]
// ---------------------------------------------------------------------------
// Sparse argmax / argmin package
// Field widths, configuration register indexes and shared types.
// ---------------------------------------------------------------------------
package sam_pkg;

  localparam int unsigned ValueFieldBits = 32;
  localparam int unsigned PosBits        = 16;
  localparam int unsigned IndexBits      = 16;
  localparam int unsigned CfgIndexBits   = 2;
  localparam int unsigned CfgDataBits    = 16;
  localparam int unsigned InDataBits     = ValueFieldBits + PosBits;

  localparam logic [CfgIndexBits-1:0] RegFindMinimum = 2'd0;
  localparam logic [CfgIndexBits-1:0] RegSparseMode  = 2'd1;
  localparam logic [CfgIndexBits-1:0] RegRunLength   = 2'd2;

  typedef struct packed {
    logic               find_minimum;
    logic               sparse_mode;
    logic [PosBits-1:0] run_length;
  } cfg_t;

  // Counter width: holds MAX_LENGTH and never narrower than a position.
  function automatic int unsigned cnt_bits(input int unsigned max_length);
    int unsigned bits;
    bits = $clog2(max_length + 1);
    return (bits > PosBits) ? bits : PosBits;
  endfunction

endpackage

[rtl/sparse_argmax_argmin_unit.sv]
// Path: a closing item passes the input register, the snapshot and the output register.
// Throughput: one item per cycle; a closing item waits while the snapshot is blocked.
// Each element needs one compare-and-select and one gap update in the run tracker.
// Reset: clears the configuration to its defaults, the run state and all valid flags.
// No memory, so the unit is ready in the first cycle after reset.
// ---------------------------------------------------------------------------
// Sparse argmax / argmin unit
// Returns the 1-based index of the greatest or least element of each run of
// integer elements, with unstored positions counted as zero in sparse mode.
// ---------------------------------------------------------------------------
module sparse_argmax_argmin_unit #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_LENGTH = 65535
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sam_pkg::CfgIndexBits-1:0]     cfg_index_i,
  input  logic [sam_pkg::CfgDataBits-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: value (32), position (16).
  input  logic [sam_pkg::InDataBits-1:0]       s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // Fields from bit 0: empty_run (1).
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: winner_index (16).
  output logic [sam_pkg::IndexBits-1:0]        m_axis_tdata,
  // Fields from bit 0: status (1).
  output logic                                 m_axis_tuser
);

  localparam int unsigned CntW = sam_pkg::cnt_bits(MAX_LENGTH);
  localparam int unsigned VfW  = sam_pkg::ValueFieldBits;
  localparam int unsigned PosW = sam_pkg::PosBits;

  sam_pkg::cfg_t cfg_q, cfg_d;

  logic            in_valid_q;
  logic [VfW-1:0]  in_value_q;
  logic [PosW-1:0] in_position_q;
  logic            in_last_q;
  logic            in_empty_q;
  logic            item_ready;
  logic [VALUE_BITS-1:0] item_value;

  logic                  snap_valid, snap_ready;
  logic [VALUE_BITS-1:0] snap_best_value;
  logic [CntW-1:0]       snap_best_index, snap_items_seen, snap_first_gap;
  logic [PosW-1:0]       snap_prev_position, snap_last_gap;
  logic                  snap_first_gap_found;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        sam_pkg::RegFindMinimum: cfg_d.find_minimum = cfg_data_i[0];
        sam_pkg::RegSparseMode:  cfg_d.sparse_mode  = cfg_data_i[0];
        sam_pkg::RegRunLength:   cfg_d.run_length   = cfg_data_i;
        default:                 cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.find_minimum <= 1'b0;
      cfg_q.sparse_mode  <= 1'b0;
      cfg_q.run_length   <= PosW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign s_axis_tready = !in_valid_q || item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_value_q    <= s_axis_tdata[VfW-1:0];
      in_position_q <= s_axis_tdata[VfW+PosW-1:VfW];
      in_last_q     <= s_axis_tlast;
      in_empty_q    <= s_axis_tuser;
    end
  end

  assign item_value = VALUE_BITS'(in_value_q);

  sam_run_tracker #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_tracker (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg_q),
    .item_valid_i           (in_valid_q),
    .item_ready_o           (item_ready),
    .value_i                (item_value),
    .position_i             (in_position_q),
    .last_i                 (in_last_q),
    .empty_i                (in_empty_q),
    .snap_valid_o           (snap_valid),
    .snap_ready_i           (snap_ready),
    .snap_best_value_o      (snap_best_value),
    .snap_best_index_o      (snap_best_index),
    .snap_items_seen_o      (snap_items_seen),
    .snap_prev_position_o   (snap_prev_position),
    .snap_first_gap_o       (snap_first_gap),
    .snap_first_gap_found_o (snap_first_gap_found),
    .snap_last_gap_o        (snap_last_gap)
  );

  sam_resolver #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_resolver (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg_q),
    .snap_valid_i           (snap_valid),
    .snap_ready_o           (snap_ready),
    .snap_best_value_i      (snap_best_value),
    .snap_best_index_i      (snap_best_index),
    .snap_items_seen_i      (snap_items_seen),
    .snap_prev_position_i   (snap_prev_position),
    .snap_first_gap_i       (snap_first_gap),
    .snap_first_gap_found_i (snap_first_gap_found),
    .snap_last_gap_i        (snap_last_gap),
    .out_valid_o            (m_axis_tvalid),
    .out_ready_i            (m_axis_tready),
    .out_index_o            (m_axis_tdata),
    .out_status_o           (m_axis_tuser)
  );

endmodule

[rtl/sam_run_tracker.sv]
// ---------------------------------------------------------------------------
// Run tracker
// Compares each element with the running best, tracks gaps and counts, and
// hands a snapshot of the run state to the resolver when a run closes.
// ---------------------------------------------------------------------------
`include "sparse_argmax_argmin_unit_macros.svh"

module sam_run_tracker #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_LENGTH = 65535
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sam_pkg::cfg_t                         cfg_i,
  input  logic                                  item_valid_i,
  output logic                                  item_ready_o,
  input  logic [VALUE_BITS-1:0]                 value_i,
  input  logic [sam_pkg::PosBits-1:0]           position_i,
  input  logic                                  last_i,
  input  logic                                  empty_i,
  output logic                                  snap_valid_o,
  input  logic                                  snap_ready_i,
  output logic [VALUE_BITS-1:0]                 snap_best_value_o,
  output logic [sam_pkg::cnt_bits(MAX_LENGTH)-1:0] snap_best_index_o,
  output logic [sam_pkg::cnt_bits(MAX_LENGTH)-1:0] snap_items_seen_o,
  output logic [sam_pkg::PosBits-1:0]           snap_prev_position_o,
  output logic [sam_pkg::cnt_bits(MAX_LENGTH)-1:0] snap_first_gap_o,
  output logic                                  snap_first_gap_found_o,
  output logic [sam_pkg::PosBits-1:0]           snap_last_gap_o
);

  localparam int unsigned CntW = sam_pkg::cnt_bits(MAX_LENGTH);
  localparam int unsigned PosW = sam_pkg::PosBits;

  typedef struct packed {
    logic [VALUE_BITS-1:0] best_value;
    logic [CntW-1:0]       best_index;
    logic [CntW-1:0]       items_seen;
    logic [PosW-1:0]       prev_position;
    logic [CntW-1:0]       first_gap;
    logic                  first_gap_found;
    logic [PosW-1:0]       last_gap;
  } run_t;

  run_t run_q, run_d, take, snap_q, snap_d;
  logic snap_valid_q, snap_valid_d;
  logic closing, consume, better;
  logic [CntW-1:0] items_inc, pos_ext;
  logic [VALUE_BITS-1:0] new_key, best_key;

  assign closing      = last_i | empty_i;
  assign item_ready_o = !closing || !snap_valid_q || snap_ready_i;
  assign consume      = item_valid_i && item_ready_o;

  assign items_inc = (run_q.items_seen == CntW'(MAX_LENGTH)) ? run_q.items_seen
                                                             : run_q.items_seen + 1'b1;
  assign pos_ext   = CntW'(position_i);
  assign new_key   = {~value_i[VALUE_BITS-1], value_i[VALUE_BITS-2:0]};
  assign best_key  = {~run_q.best_value[VALUE_BITS-1], run_q.best_value[VALUE_BITS-2:0]};

  always_comb begin
    if (run_q.items_seen == '0) begin
      better = 1'b1;
    end else if (cfg_i.find_minimum) begin
      better = new_key <= best_key;
    end else begin
      better = new_key > best_key;
    end
  end

  always_comb begin
    take            = run_q;
    take.items_seen = items_inc;
    if (cfg_i.sparse_mode) begin
      if (!run_q.first_gap_found && (items_inc < pos_ext)) begin
        take.first_gap       = items_inc;
        take.first_gap_found = 1'b1;
      end
      if ({1'b0, position_i} > ({1'b0, run_q.prev_position} + 17'd1)) begin
        take.last_gap = position_i - 1'b1;
      end
      take.prev_position = position_i;
    end
    if (better) begin
      take.best_value = value_i;
      take.best_index = cfg_i.sparse_mode ? pos_ext : items_inc;
    end
  end

  always_comb begin
    run_d        = run_q;
    snap_d       = snap_q;
    snap_valid_d = snap_valid_q && !snap_ready_i;
    if (consume) begin
      if (empty_i) begin
        snap_d       = run_q;
        snap_valid_d = 1'b1;
        run_d        = '0;
      end else if (last_i) begin
        snap_d       = take;
        snap_valid_d = 1'b1;
        run_d        = '0;
      end else begin
        run_d = take;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      run_q        <= run_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_valid_o           = snap_valid_q;
  assign snap_best_value_o      = snap_q.best_value;
  assign snap_best_index_o      = snap_q.best_index;
  assign snap_items_seen_o      = snap_q.items_seen;
  assign snap_prev_position_o   = snap_q.prev_position;
  assign snap_first_gap_o       = snap_q.first_gap;
  assign snap_first_gap_found_o = snap_q.first_gap_found;
  assign snap_last_gap_o        = snap_q.last_gap;

  `SAM_ASSERT_NEXT(a_run_cleared, clk_i, rst_ni, consume && closing, run_q.items_seen == '0, "run state not cleared after a closing item")
  `SAM_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, run_q.items_seen <= CntW'(MAX_LENGTH), "element count beyond the length limit")
  `SAM_ASSERT_SAME(a_first_gap, clk_i, rst_ni, run_q.first_gap_found, (run_q.first_gap != '0) && (run_q.first_gap <= run_q.items_seen), "first gap outside the elements seen")

endmodule

[rtl/sam_resolver.sv]
// ---------------------------------------------------------------------------
// Run resolver
// Turns a closed run's snapshot into the winner index and status, letting an
// implicit zero win in sparse mode, and holds the result in the output stage.
// ---------------------------------------------------------------------------
`include "sparse_argmax_argmin_unit_macros.svh"

module sam_resolver #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_LENGTH = 65535
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sam_pkg::cfg_t                         cfg_i,
  input  logic                                  snap_valid_i,
  output logic                                  snap_ready_o,
  input  logic [VALUE_BITS-1:0]                 snap_best_value_i,
  input  logic [sam_pkg::cnt_bits(MAX_LENGTH)-1:0] snap_best_index_i,
  input  logic [sam_pkg::cnt_bits(MAX_LENGTH)-1:0] snap_items_seen_i,
  input  logic [sam_pkg::PosBits-1:0]           snap_prev_position_i,
  input  logic [sam_pkg::cnt_bits(MAX_LENGTH)-1:0] snap_first_gap_i,
  input  logic                                  snap_first_gap_found_i,
  input  logic [sam_pkg::PosBits-1:0]           snap_last_gap_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [sam_pkg::IndexBits-1:0]         out_index_o,
  output logic                                  out_status_o
);

  localparam int unsigned CntW = sam_pkg::cnt_bits(MAX_LENGTH);

  logic out_valid_q, out_valid_d;
  logic [sam_pkg::IndexBits-1:0] out_index_q, out_index_d;
  logic out_status_q, out_status_d;
  logic out_free;
  logic is_neg, is_zero;
  logic [CntW:0] idx, gap_j;
  logic status;

  assign is_neg  = snap_best_value_i[VALUE_BITS-1];
  assign is_zero = (snap_best_value_i == '0);

  always_comb begin
    idx    = '0;
    gap_j  = '0;
    status = 1'b0;
    if (cfg_i.sparse_mode && (cfg_i.run_length == '0)) begin
      status = 1'b1;
    end else if (snap_items_seen_i == '0) begin
      if (cfg_i.sparse_mode) begin
        idx = cfg_i.find_minimum ? (CntW+1)'(cfg_i.run_length) : (CntW+1)'(1);
      end else begin
        status = 1'b1;
      end
    end else begin
      idx = {1'b0, snap_best_index_i};
      if (cfg_i.sparse_mode && (snap_items_seen_i < CntW'(cfg_i.run_length))) begin
        if (!cfg_i.find_minimum) begin
          if (is_neg || is_zero) begin
            gap_j = snap_first_gap_found_i ? {1'b0, snap_first_gap_i}
                                           : {1'b0, snap_items_seen_i} + 1'b1;
            if (is_neg || (gap_j < idx)) begin
              idx = gap_j;
            end
          end
        end else begin
          if (!is_neg) begin
            gap_j = (snap_prev_position_i < cfg_i.run_length)
                  ? (CntW+1)'(cfg_i.run_length) : (CntW+1)'(snap_last_gap_i);
            if (!is_zero || (gap_j > idx)) begin
              idx = gap_j;
            end
          end
        end
      end
    end
  end

  assign out_free     = !out_valid_q || out_ready_i;
  assign snap_ready_o = out_free;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_index_d  = out_index_q;
    out_status_d = out_status_q;
    if (out_free) begin
      out_valid_d = snap_valid_i;
      if (snap_valid_i) begin
        out_index_d  = idx[sam_pkg::IndexBits-1:0];
        out_status_d = status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_index_q  <= out_index_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_status_o = out_status_q;

  `SAM_ASSERT_SAME(a_error_index, clk_i, rst_ni, out_valid_q && out_status_q, out_index_q == '0, "error result with a nonzero index")
  `SAM_ASSERT_NEXT(a_result_taken, clk_i, rst_ni, snap_valid_i && out_free, out_valid_q, "snapshot taken but no result registered")

endmodule

[bench/tb_top.sv]
// ---------------------------------------------------------------------------
// Testbench for the sparse argmax / argmin unit
// Streams dense and sparse integer runs into the unit, predicts the winning
// index and status of every closing item and compares each returned item,
// with random idle cycles on both stream sides and a no-progress watchdog.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxLength   = 65535;
  localparam logic [31:0] SignBit     = 32'h8000_0000;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned PrintLimit  = 40;

  typedef struct packed {
    logic [sam_pkg::IndexBits-1:0] winner;
    logic                          status;
  } verdict_t;

  logic                             clk_i          = 1'b0;
  logic                             rst_ni         = 1'b0;
  logic                             cfg_valid_i    = 1'b0;
  logic [sam_pkg::CfgIndexBits-1:0] cfg_index_i    = sam_pkg::RegFindMinimum;
  logic [sam_pkg::CfgDataBits-1:0]  cfg_data_i     = '0;
  logic                             s_axis_tvalid  = 1'b0;
  logic [sam_pkg::InDataBits-1:0]   s_axis_tdata   = '0;
  logic                             s_axis_tlast   = 1'b0;
  logic                             s_axis_tuser   = 1'b0;
  logic                             m_axis_tready  = 1'b0;
  logic                             cfg_ready_o;
  logic                             s_axis_tready;
  logic                             m_axis_tvalid;
  logic [sam_pkg::IndexBits-1:0]    m_axis_tdata;
  logic                             m_axis_tuser;

  sparse_argmax_argmin_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic        cfg_find_min = 1'b0;
  logic        cfg_sparse   = 1'b0;
  logic [15:0] cfg_run_len  = 16'd1;

  logic [31:0] top_value        = '0;
  int unsigned top_index        = 0;
  int unsigned elem_count       = 0;
  int unsigned prev_pos         = 0;
  int unsigned first_hole       = 0;
  logic        first_hole_found = 1'b0;
  int unsigned last_hole        = 0;

  verdict_t    expected_verdicts[$];
  bit          no_idle       = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned dense_runs    = 0;
  int unsigned sparse_runs   = 0;
  int unsigned idle_cycles   = 0;

  task automatic clear_run_state();
    top_value        = '0;
    top_index        = 0;
    elem_count       = 0;
    prev_pos         = 0;
    first_hole       = 0;
    first_hole_found = 1'b0;
    last_hole        = 0;
  endtask

  task automatic absorb_element(input logic [31:0] value, input logic [15:0] pos);
    logic        is_first;
    logic        better;
    int unsigned idx;
    is_first = (elem_count == 0);
    if (elem_count < MaxLength) elem_count++;
    if (cfg_sparse) begin
      idx = 32'(pos);
      if (!first_hole_found && elem_count < pos) begin
        first_hole       = elem_count;
        first_hole_found = 1'b1;
      end
      if (pos > prev_pos + 1) last_hole = pos - 1;
      prev_pos = 32'(pos);
    end else begin
      idx = elem_count;
    end
    if (is_first) better = 1'b1;
    else if (cfg_find_min) better = (value ^ SignBit) <= (top_value ^ SignBit);
    else better = (value ^ SignBit) > (top_value ^ SignBit);
    if (better) begin
      top_value = value;
      top_index = idx;
    end
  endtask

  task automatic close_run();
    int unsigned idx;
    int unsigned hole;
    logic        status;
    logic [31:0] key;
    verdict_t    v;
    idx    = 0;
    status = 1'b0;
    if (cfg_sparse && cfg_run_len == 0) begin
      status = 1'b1;
    end else if (elem_count == 0) begin
      if (cfg_sparse) idx = cfg_find_min ? 32'(cfg_run_len) : 1;
      else status = 1'b1;
    end else begin
      idx = top_index;
      if (cfg_sparse && elem_count < cfg_run_len) begin
        key = top_value ^ SignBit;
        if (!cfg_find_min) begin
          if (key <= SignBit) begin
            hole = first_hole_found ? first_hole : elem_count + 1;
            if (key < SignBit || hole < idx) idx = hole;
          end
        end else begin
          if (key >= SignBit) begin
            hole = (prev_pos < cfg_run_len) ? 32'(cfg_run_len) : last_hole;
            if (key > SignBit || hole > idx) idx = hole;
          end
        end
      end
    end
    v.winner = idx[sam_pkg::IndexBits-1:0];
    v.status = status;
    expected_verdicts.push_back(v);
    if (cfg_sparse) sparse_runs++;
    else dense_runs++;
    clear_run_state();
  endtask

  task automatic send_item(input logic [31:0] value, input logic [15:0] pos,
                           input bit is_last, input bit is_empty);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, value};
    s_axis_tlast  <= is_last;
    s_axis_tuser  <= is_empty;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (is_empty) begin
      close_run();
    end else begin
      absorb_element(value, pos);
      if (is_last) close_run();
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_verdicts.size() != 0);
  endtask

  task automatic write_register(input logic [sam_pkg::CfgIndexBits-1:0] idx,
                                input logic [sam_pkg::CfgDataBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sam_pkg::RegFindMinimum: cfg_find_min = data[0];
      sam_pkg::RegSparseMode:  cfg_sparse   = data[0];
      sam_pkg::RegRunLength:   cfg_run_len  = data;
      default: ;
    endcase
  endtask

  // Writes go in only while the unit is idle; the short pause covers its latency.
  task automatic write_config(input logic [2:0] mask, input logic find_min,
                              input logic sparse, input logic [15:0] run_len);
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mask[0]) write_register(sam_pkg::RegFindMinimum, {15'($urandom()), find_min});
    if (mask[1]) write_register(sam_pkg::RegSparseMode, {15'($urandom()), sparse});
    if (mask[2]) write_register(sam_pkg::RegRunLength, run_len);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] any_pos();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] any_value(input bit narrow);
    int s;
    if (narrow) begin
      s = int'($urandom_range(0, 4)) - 2;
      return s;
    end
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("mismatch on %s: got %0d, expected %0d (result %0d)",
               field, got, want, results_seen);
  endtask

  task automatic check_result(input logic [sam_pkg::IndexBits-1:0] winner,
                              input logic status);
    verdict_t want;
    results_seen++;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("unexpected item", 32'(winner), 0);
      return;
    end
    want = expected_verdicts.pop_front();
    if (winner !== want.winner)
      report_mismatch("winner_index", 32'(winner), 32'(want.winner));
    if (status !== want.status)
      report_mismatch("status", 32'(status), 32'(want.status));
  endtask

  initial begin
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_dense_directed();
    write_config(3'b111, 1'b0, 1'b0, 16'd1);
    send_item(32'h7FFF_FFFF, any_pos(), 1'b0, 1'b0);
    send_item(32'h8000_0000, any_pos(), 1'b0, 1'b0);
    send_item(32'h7FFF_FFFF, any_pos(), 1'b1, 1'b0);
    send_item($urandom(), any_pos(), 1'b0, 1'b1);
    write_config(3'b001, 1'b1, 1'b0, 16'd1);
    send_item(32'h8000_0000, any_pos(), 1'b0, 1'b0);
    send_item(32'hFFFF_FFFF, any_pos(), 1'b0, 1'b0);
    send_item(32'h8000_0000, any_pos(), 1'b1, 1'b0);
    send_item(32'd5, any_pos(), 1'b0, 1'b0);
    send_item(32'd7, any_pos(), 1'b1, 1'b1);
  endtask

  task automatic test_sparse_directed();
    write_config(3'b111, 1'b0, 1'b1, 16'd6);
    send_item(-32'sd5, 16'd2, 1'b0, 1'b0);
    send_item(-32'sd3, 16'd4, 1'b1, 1'b0);
    send_item(32'd0, 16'd1, 1'b0, 1'b0);
    send_item(32'd0, 16'd3, 1'b1, 1'b0);
    send_item($urandom(), any_pos(), 1'b0, 1'b1);
    write_config(3'b001, 1'b1, 1'b1, 16'd6);
    send_item(32'd4, 16'd1, 1'b0, 1'b0);
    send_item(32'd9, 16'd2, 1'b1, 1'b0);
    send_item($urandom(), any_pos(), 1'b1, 1'b1);
    send_item(-32'sd1, 16'd5, 1'b0, 1'b0);
    send_item(-32'sd2, 16'd3, 1'b0, 1'b0);
    send_item(32'd3, 16'd0, 1'b1, 1'b0);
    write_config(3'b100, 1'b1, 1'b1, 16'd0);
    send_item(32'd1, 16'd1, 1'b1, 1'b0);
    write_config(3'b101, 1'b0, 1'b1, 16'hFFFF);
    send_item(-32'sd7, 16'hFFFF, 1'b1, 1'b0);
  endtask

  task automatic random_run();
    int unsigned kind;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned pos;
    bit          narrow;
    bit          close_last;
    kind   = $urandom_range(0, 99);
    narrow = 1'($urandom_range(0, 1));
    if (kind < 4) begin
      send_item(any_value(narrow), any_pos(), 1'($urandom_range(0, 1)), 1'b1);
    end else if (kind < 12) begin
      // Scrambled positions, and runs cut short by an empty mark.
      n = $urandom_range(1, 6);
      for (int unsigned k = 0; k < n; k++) send_item(any_value(narrow), any_pos(), 1'b0, 1'b0);
      close_last = 1'($urandom_range(0, 1));
      send_item(any_value(narrow), any_pos(), close_last,
                close_last ? bit'($urandom_range(0, 1)) : 1'b1);
    end else if (cfg_sparse && cfg_run_len != 0) begin
      if (cfg_run_len <= 10 && $urandom_range(0, 4) == 0) n = 32'(cfg_run_len);
      else n = $urandom_range(0, (cfg_run_len < 10) ? 32'(cfg_run_len) : 10);
      if (n == 0) begin
        send_item(any_value(narrow), any_pos(), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        pos = 0;
        for (int unsigned k = 0; k < n; k++) begin
          lo = pos + 1;
          hi = cfg_run_len - (n - 1 - k);
          if (hi > lo + 2 && $urandom_range(0, 3) != 0) hi = lo + 2;
          pos = $urandom_range(lo, hi);
          send_item(any_value(narrow), pos[15:0], k == n - 1, 1'b0);
        end
      end
    end else begin
      n = $urandom_range(1, 12);
      for (int unsigned k = 0; k < n; k++)
        send_item(any_value(narrow), any_pos(), k == n - 1, 1'b0);
    end
  endtask

  task automatic test_random_runs();
    int unsigned base;
    int unsigned phase_end;
    logic [15:0] run_len;
    base = items_sent;
    while (items_sent - base < RandomItems) begin
      case ($urandom_range(0, 15))
        0:       run_len = 16'd0;
        1, 2:    run_len = 16'd1;
        3, 4:    run_len = 16'hFFFF;
        5:       run_len = 16'($urandom_range(1, 65535));
        default: run_len = 16'($urandom_range(2, 12));
      endcase
      write_config(3'($urandom_range(1, 7)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 4) != 0, run_len);
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_end = items_sent - base + $urandom_range(30, 80);
      while (items_sent - base < phase_end) begin
        random_run();
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_dense_directed();
    test_sparse_directed();
    test_random_runs();
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d items closing %0d dense and %0d sparse runs; checked %0d results.",
             items_sent, dense_runs, sparse_runs, results_seen);
    $display("Mismatches found: %0d; results still awaited: %0d.",
             mismatches, expected_verdicts.size());
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
